>>> sv/mm64_pkg.sv
`default_nettype none

package mm64_pkg;

   // Hash constants.
   localparam logic [63:0] MUL_M      = 64'hc6a4a7935bd1e995;
   localparam int          SHIFT_R    = 47;
   localparam logic [63:0] SEED_RESET = 64'hcbf29ce484222325;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Command kinds, set by the front from the valid byte count.
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_PART = 2'd1;
   localparam logic [1:0] CMD_FULL = 2'd2;

   // One classified item as it travels through the queue.
   typedef struct packed {
      logic [1:0]  kind;
      logic        first;
      logic        last;
      logic [31:0] length;
      logic [63:0] word;
   } cmd_type;

endpackage

`default_nettype wire

>>> sv/mm64_queue.sv
`default_nettype none

module mm64_queue
   import mm64_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         head_valid
);

   cmd_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   // Status and read side.
   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/mm64_front.sv
`default_nettype none

module mm64_front
   import mm64_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_valid_bytes,
   input  wire logic [31:0] req_message_length,
   input  wire logic        req_first_item,
   input  wire logic        req_last_item,
   input  wire logic        cmd_pop,
   output cmd_type          cmd_head,
   output logic             cmd_head_valid
);

   logic    q_full;
   logic    push;
   logic [3:0] nbytes;
   cmd_type cmd;

   // Classify the item: counts above eight act as a full word, and unused
   // bytes are cleared so the back can xor the word in directly.
   always_comb begin
      nbytes = req_valid_bytes[3] ? 4'd8 : req_valid_bytes;
      cmd.first  = req_first_item;
      cmd.last   = req_last_item;
      cmd.length = req_message_length;
      if (nbytes == 4'd8) begin
         cmd.kind = CMD_FULL;
      end else if (nbytes == 4'd0) begin
         cmd.kind = CMD_NONE;
      end else begin
         cmd.kind = CMD_PART;
      end
      for (int i = 0; i < 8; i++) begin
         cmd.word[8*i +: 8] = (4'(i) < nbytes) ? req_data_word[8*i +: 8] : 8'h00;
      end
   end

   assign req_ready = ~q_full;
   assign push      = req_valid & ~q_full;

   mm64_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (cmd),
      .full       (q_full),
      .pop        (cmd_pop),
      .head       (cmd_head),
      .head_valid (cmd_head_valid)
   );

endmodule

`default_nettype wire

>>> sv/mm64_mul.sv
`default_nettype none

module mm64_mul
   import mm64_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] operand,
   output logic             done,
   output logic [63:0]      product
);

   // Computes operand * MUL_M modulo 2^64 with one 32x32 multiplier, step by
   // step: low x low, then the two cross terms into the upper half.
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic [1:0]  step_eff;
   logic        done_ff, done_in;
   logic [63:0] x_sel;
   logic [31:0] mul_a, mul_b;
   logic [63:0] pp;

   always_comb begin
      step_eff = start ? 2'd0 : step_ff;
      x_sel    = start ? operand : x_ff;
      mul_a    = (step_eff == 2'd2) ? x_sel[63:32] : x_sel[31:0];
      mul_b    = (step_eff == 2'd1) ? MUL_M[63:32] : MUL_M[31:0];
      pp       = 64'(mul_a) * 64'(mul_b);
   end

   // Step sequencing and accumulation.
   always_comb begin
      x_in    = x_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = operand;
         acc_in  = pp;
         step_in = 2'd1;
      end else if (step_ff != 2'd0) begin
         acc_in = {acc_ff[63:32] + pp[31:0], acc_ff[31:0]};
         if (step_ff == 2'd2) begin
            step_in = 2'd0;
            done_in = 1'b1;
         end else begin
            step_in = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

>>> sv/mm64_back.sv
`default_nettype none

module mm64_back
   import mm64_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [63:0] csr_wr_data,
   input  wire cmd_type     cmd_head,
   input  wire logic        cmd_head_valid,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_hash_value
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LEN  = 3'd1;
   localparam logic [2:0] ST_K1   = 3'd2;
   localparam logic [2:0] ST_K2   = 3'd3;
   localparam logic [2:0] ST_HASH = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]  state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [63:0] seed_ff, seed_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] fin_ff, fin_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;
   logic        mul_start;
   logic [63:0] mul_opnd;
   logic        mul_done;
   logic [63:0] mul_prod;
   logic [63:0] prod_mix;
   logic        disp_en;
   cmd_type     disp_cmd;
   logic [63:0] disp_hash;

   mm64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (mul_opnd),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign prod_mix = mul_prod ^ (mul_prod >> SHIFT_R);
   assign seed_in  = csr_wr_en ? csr_wr_data : seed_ff;

   // Sequencer: each state but idle and output waits for the shared
   // multiplier, uses its product and starts any next multiply.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      hash_in      = hash_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      mul_start    = 1'b0;
      mul_opnd     = '0;
      cmd_pop      = 1'b0;
      disp_en      = 1'b0;
      disp_cmd     = cmd_ff;
      disp_hash    = hash_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_head_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_head;
               if (cmd_head.first) begin
                  mul_start = 1'b1;
                  mul_opnd  = {32'b0, cmd_head.length};
                  state_in  = ST_LEN;
               end else begin
                  disp_en  = 1'b1;
                  disp_cmd = cmd_head;
               end
            end
         end
         ST_LEN: begin
            if (mul_done) begin
               hash_in   = seed_ff ^ mul_prod;
               disp_en   = 1'b1;
               disp_hash = seed_ff ^ mul_prod;
            end
         end
         ST_K1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_opnd  = prod_mix;
               state_in  = ST_K2;
            end
         end
         ST_K2: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_opnd  = hash_ff ^ mul_prod;
               state_in  = ST_HASH;
            end
         end
         ST_HASH: begin
            if (mul_done) begin
               hash_in = mul_prod;
               if (cmd_ff.last) begin
                  mul_start = 1'b1;
                  mul_opnd  = prod_mix;
                  state_in  = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIN: begin
            if (mul_done) begin
               fin_in   = prod_mix;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = fin_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Once the start value of the hash is known, pick the work by kind.
      if (disp_en) begin
         unique case (disp_cmd.kind)
            CMD_FULL: begin
               mul_start = 1'b1;
               mul_opnd  = disp_cmd.word;
               state_in  = ST_K1;
            end
            CMD_PART: begin
               mul_start = 1'b1;
               mul_opnd  = disp_hash ^ disp_cmd.word;
               state_in  = ST_HASH;
            end
            default: begin
               if (disp_cmd.last) begin
                  mul_start = 1'b1;
                  mul_opnd  = disp_hash ^ (disp_hash >> SHIFT_R);
                  state_in  = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      fin_ff      <= fin_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

`default_nettype wire

>>> sv/murmur64a_hash_stream_top.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    data_word, valid_bytes, message_length,
//                                         first_item, last_item
// rsp       out        rsp_valid/ready    hash_value (on last items only)
// csr       in         csr_wr_en          csr_wr_data -> hash_seed
//
// Every 64-bit multiply by the constant runs on the single
// shared 32x32 multiplier in the back end; the back works on one item at a time.
// A full word takes three multiplies, a partial word one, an empty word none;
// a first item adds one multiply for the length, and a last item one multiply
// and then the output state, which loads the output register.
// Reset is synchronous; it empties the two-entry queue, clears the running
// hash and loads the seed with its default.
// The queue keeps taking items, until it is full, while the back works or while a result waits.
`default_nettype none

module murmur64a_hash_stream_top
   import mm64_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_valid_bytes,
   input  wire logic [31:0] req_message_length,
   input  wire logic        req_first_item,
   input  wire logic        req_last_item,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_hash_value,
   input  wire logic        csr_wr_en,
   input  wire logic [63:0] csr_wr_data
);

   cmd_type cmd_head;
   logic    cmd_head_valid;
   logic    cmd_pop;

   // Front end: classify items and queue them.
   mm64_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_valid_bytes    (req_valid_bytes),
      .req_message_length (req_message_length),
      .req_first_item     (req_first_item),
      .req_last_item      (req_last_item),
      .cmd_pop            (cmd_pop),
      .cmd_head           (cmd_head),
      .cmd_head_valid     (cmd_head_valid)
   );

   // Back end: hash arithmetic and the result register.
   mm64_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd_head       (cmd_head),
      .cmd_head_valid (cmd_head_valid),
      .cmd_pop        (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire

>>> sv/mm64_checker.sv
`default_nettype none

module mm64_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_hash_value
);

   // A result that is not taken stays and keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Reset empties the queue, so the input side is open again.
   assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

   // A valid result always carries a fully known hash.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_hash_value))
      else $error("result hash unknown");

endmodule

bind murmur64a_hash_stream_top mm64_checker u_mm64_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_value (rsp_hash_value)
);

`default_nettype wire

>>> tb/murmur64a_hash_stream_top_test.sv
`timescale 1ns / 100ps

module murmur64a_hash_stream_top_test;
   import mm64_pkg::*;

   localparam int unsigned ITEM_TARGET   = 1100;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam logic [63:0] ALL_ONES      = '1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_data_word;
   logic [3:0]  req_valid_bytes;
   logic [31:0] req_message_length;
   logic        req_first_item;
   logic        req_last_item;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_hash_value;
   logic        csr_wr_en;
   logic [63:0] csr_wr_data;

   // Shadow of the block's seed and running hash, and the hashes still owed.
   logic [63:0] seed_model;
   logic [63:0] hash_model;
   logic [63:0] expected_hashes[$];

   int unsigned hash_errors;
   int unsigned items_sent;
   bit          no_idle;
   bit          hold_request;

   murmur64a_hash_stream_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_valid_bytes    (req_valid_bytes),
      .req_message_length (req_message_length),
      .req_first_item     (req_first_item),
      .req_last_item      (req_last_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hash_value     (rsp_hash_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // Free-running clock with a 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Fold one accepted item into the shadow hash; a last item owes a finalized hash.
   task automatic advance_hash_model(input logic [63:0] word, input logic [3:0] nbytes,
                                     input logic [31:0] length, input logic first,
                                     input logic last);
      logic [63:0] h;
      logic [63:0] k;
      logic [63:0] mask;
      int unsigned n;
      n = (nbytes > 4'd8) ? 8 : nbytes;
      h = first ? (seed_model ^ ({32'd0, length} * MUL_M)) : hash_model;
      if (n == 8) begin
         k = word * MUL_M;
         k = k ^ (k >> SHIFT_R);
         k = k * MUL_M;
         h = (h ^ k) * MUL_M;
      end else if (n != 0) begin
         mask = (64'd1 << (8 * n)) - 64'd1;
         h = (h ^ (word & mask)) * MUL_M;
      end
      hash_model = h;
      if (last) begin
         h = h ^ (h >> SHIFT_R);
         h = h * MUL_M;
         h = h ^ (h >> SHIFT_R);
         expected_hashes.push_back(h);
      end
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic report_hash_error(input string what, input logic [63:0] want,
                                    input logic [63:0] got);
      hash_errors++;
      if (hash_errors <= 10) begin
         $display("hash mismatch (%s): expected %h, got %h", what, want, got);
      end
   endtask

   // Offer one item after a random gap and hold it until it is taken.
   task automatic send_item(input logic [63:0] word, input logic [3:0] nbytes,
                            input logic [31:0] length, input logic first,
                            input logic last);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_data_word      = word;
      req_valid_bytes    = nbytes;
      req_message_length = length;
      req_first_item     = first;
      req_last_item      = last;
      req_valid          = 1'b1;
      do @(posedge clock); while (!req_ready);
      advance_hash_model(word, nbytes, length, first, last);
      if (nbytes != 4'd0 || first || last) begin
         items_sent++;
      end
   endtask

   // Split byte_count bytes into words; the final word carries the last mark.
   task automatic send_message(input logic [31:0] length, input int unsigned byte_count,
                               input bit with_first);
      int unsigned left;
      int unsigned idx;
      logic [3:0]  vb;
      left = byte_count;
      idx  = 0;
      if (left == 0) begin
         send_item(rand_word(), 4'd0, length, with_first, 1'b1);
      end
      while (left > 0) begin
         vb = (left >= 8) ? 4'd8 : 4'(left);
         // Counts above eight stand for a full word.
         if (vb == 4'd8 && $urandom_range(0, 7) == 0) begin
            vb = 4'($urandom_range(9, 15));
         end
         send_item(rand_word(), vb, length, with_first && idx == 0, left <= 8);
         left = (left >= 8) ? left - 8 : 0;
         idx++;
      end
   endtask

   // Stop offering items and wait for every owed hash.
   task automatic wait_for_results;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_hashes.size() != 0) @(posedge clock);
   endtask

   // The seed is only changed once the block has run dry.
   task automatic write_seed(input logic [63:0] value);
      wait_for_results;
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      seed_model  = value;
   endtask

   // Items that never had a first item continue from the cleared hash.
   task automatic test_no_first_after_reset;
      send_item(ALL_ONES, 4'd8, 32'd0, 1'b0, 1'b0);
      send_item(64'h0123_4567_89ab_cdef, 4'd0, 32'd0, 1'b0, 1'b1);
   endtask

   // Edge cases under the default seed.
   task automatic test_directed_messages;
      send_item(ALL_ONES, 4'd0, 32'd0, 1'b1, 1'b1);
      send_item(ALL_ONES, 4'd1, 32'd1, 1'b1, 1'b1);
      send_item(ALL_ONES, 4'd7, 32'd7, 1'b1, 1'b1);
      send_item(64'd0, 4'd8, 32'd16, 1'b1, 1'b0);
      send_item(ALL_ONES, 4'd8, 32'd16, 1'b0, 1'b1);
      for (int vb = 9; vb <= 15; vb++) begin
         send_item(rand_word(), 4'(vb), (vb % 2 == 1) ? 32'hffff_ffff : 32'd0,
                   1'b1, 1'b1);
      end
      // A partial word that is not last is still folded in.
      send_item(rand_word(), 4'd3, 32'd11, 1'b1, 1'b0);
      send_item(rand_word(), 4'd8, 32'd11, 1'b0, 1'b1);
      // After a last item the unfinalized hash carries on.
      send_item(rand_word(), 4'd5, 32'd0, 1'b0, 1'b1);
      send_item(ALL_ONES, 4'd0, 32'hffff_ffff, 1'b1, 1'b1);
   endtask

   task automatic test_seed_extremes;
      write_seed(64'd0);
      send_message(32'd8, 8, 1'b1);
      send_message(32'd13, 13, 1'b1);
      write_seed(ALL_ONES);
      send_message(32'd0, 0, 1'b1);
      send_message(32'd21, 21, 1'b1);
   endtask

   // The receiver stalls for a long stretch while items keep coming.
   task automatic test_backpressure;
      hold_request = 1'b1;
      for (int m = 0; m < 16; m++) begin
         send_message(32'(m % 9), m % 9, 1'b1);
      end
      send_message(32'd30, 30, 1'b1);
      wait_for_results;
   endtask

   // The sender pauses until the block is drained, then resumes mid-stream.
   task automatic test_drain_pause;
      send_message(32'd17, 17, 1'b1);
      send_item(rand_word(), 4'd8, 32'd24, 1'b1, 1'b0);
      wait_for_results;
      send_item(rand_word(), 4'd8, 32'd24, 1'b0, 1'b0);
      send_item(rand_word(), 4'd8, 32'd24, 1'b0, 1'b1);
      wait_for_results;
   endtask

   // Mostly well-formed messages, with mismatched lengths, headless runs and noise.
   task automatic send_random_message;
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(0, 15);
      if (pick <= 10) begin
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 40);
         send_message(32'(n), n, 1'b1);
      end else if (pick <= 12) begin
         send_message($urandom, $urandom_range(0, 24), 1'b1);
      end else if (pick == 13) begin
         send_message($urandom, $urandom_range(1, 24), 1'b0);
      end else if (pick == 14) begin
         send_item(rand_word(), 4'($urandom_range(0, 15)), $urandom,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
         n = $urandom_range(1, 7);
         send_item(rand_word(), 4'(n), 32'(n + 8), 1'b1, 1'b0);
         send_message(32'(n + 8), 8, 1'b0);
      end
      if ($urandom_range(0, 63) == 0) begin
         wait_for_results;
      end
   endtask

   task automatic test_random_phases;
      int unsigned phase_end;
      logic [63:0] seeds[4];
      seeds = '{{$urandom, $urandom}, ALL_ONES, 64'd0, {$urandom, $urandom}};
      for (int phase = 0; phase < 4; phase++) begin
         write_seed(seeds[phase]);
         no_idle = (phase == 2);
         phase_end = (items_sent >= ITEM_TARGET) ? items_sent
                   : items_sent + (ITEM_TARGET - items_sent) / (4 - phase);
         while (items_sent < phase_end) begin
            send_random_message();
         end
      end
      no_idle = 1'b0;
   endtask

   // Result receiver: random stalls per item, or one long hold on request.
   initial begin : result_receiver
      int unsigned stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request) begin
            stall = LONG_HOLD;
            hold_request = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
         end
         @(negedge clock);
         rsp_ready = (stall == 0);
         repeat (stall) @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Each delivered hash must match the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hashes.size() == 0) begin
            report_hash_error("unexpected item", 64'd0, rsp_hash_value);
         end else if (expected_hashes[0] !== rsp_hash_value) begin
            report_hash_error("hash_value", expected_hashes.pop_front(), rsp_hash_value);
         end else begin
            void'(expected_hashes.pop_front());
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAIL murmur64a_hash_stream_top");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data_word      = 64'd0;
      req_valid_bytes    = 4'd0;
      req_message_length = 32'd0;
      req_first_item     = 1'b0;
      req_last_item      = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = 64'd0;
      seed_model         = SEED_RESET;
      hash_model         = 64'd0;
      hash_errors        = 0;
      items_sent         = 0;
      no_idle            = 1'b0;
      hold_request       = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_no_first_after_reset();
      test_directed_messages();
      test_seed_extremes();
      test_backpressure();
      test_drain_pause();
      test_random_phases();

      // Drain, then give any stray item time to show up.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (hash_errors == 0 && expected_hashes.size() == 0) begin
         $display("PASS murmur64a_hash_stream_top");
      end else begin
         $display("FAIL murmur64a_hash_stream_top");
      end
      $finish;
   end

endmodule
